[hw/rtl/gpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gpr_pkg;

  typedef logic [7:0] pix_t;

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [1:0] {
    REG_MODE         = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_idx_t;

  localparam logic        ModeEncode       = 1'b0;
  localparam logic        ModeDecode       = 1'b1;
  localparam logic [12:0] FrameWidthReset  = 13'd4096;
  localparam logic [15:0] FrameHeightReset = 16'd4096;

endpackage

`default_nettype wire

[hw/rtl/gpr_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface gpr_in_if;
  logic          valid;
  logic          ready;
  gpr_pkg::pix_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/gpr_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface gpr_out_if;
  logic          valid;
  logic          ready;
  gpr_pkg::pix_t value;
  logic          row_end;
  logic          frame_end;

  modport source (output valid, output value, output row_end, output frame_end, input ready);
  modport sink   (input valid, input value, input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/gpr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module gpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gradient_predict_residual_2d_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Planar gradient predictor for 8-bit raster pixels: encode gives sample minus
// (left + up - upleft), decode adds the same prediction back, all modulo 256.
// One pixel per clock sustained while out_ch is ready. The line store read is
// issued at acceptance and the prediction is formed from it as the pixel moves
// into the output register, which also writes the pixel back to the line store.
// A one-column frame rereads the entry just written and takes it from the
// forwarding path. The line store has no clearing pass; the block accepts
// pixels from the first cycle after reset.
module gradient_predict_residual_2d_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gpr_in_if.sink                             in_ch,
  gpr_out_if.source                          out_ch,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [gpr_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  wire logic [gpr_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic      [gpr_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                               cfg_pready
);
  import gpr_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW >= 13) ? CW + 1 : 14;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic fwd;
    logic rend;
    logic fend;
  } s1_ctl_t;

  logic        mode_r;
  logic [12:0] frame_width_r;
  logic [15:0] frame_height_r;

  logic [CW-1:0] col_r,  col_nxt;
  logic [15:0]   row_r,  row_nxt;
  pix_t          left_r, left_nxt;
  pix_t          upleft_r, upleft_nxt;

  logic          s1_valid_r;
  pix_t          s1_sample_r;
  logic [CW-1:0] s1_x_r;
  s1_ctl_t       s1_ctl_r, s1_ctl_nxt;

  logic          out_valid_r;
  pix_t          out_value_r, out_value_nxt;
  logic          out_row_end_r, out_frame_end_r;

  logic          in_acc, s1_adv;
  logic [EW-1:0] w_raw, w_eff, col_inc;
  logic [16:0]   h_eff, row_inc;
  logic          rend, fend;
  pix_t          ram_rdata, up, lft, ul, pred, pix;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= ModeEncode;
      frame_width_r  <= FrameWidthReset;
      frame_height_r <= FrameHeightReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:         mode_r         <= cfg_pwdata[0];
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[12:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:         cfg_prdata = {{(CfgDataW-1){1'b0}}, mode_r};
      REG_FRAME_WIDTH:  cfg_prdata = {{(CfgDataW-13){1'b0}}, frame_width_r};
      REG_FRAME_HEIGHT: cfg_prdata = {{(CfgDataW-16){1'b0}}, frame_height_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    w_raw = {{(EW-13){1'b0}}, frame_width_r};
    if (w_raw == '0) begin
      w_eff = {{(EW-1){1'b0}}, 1'b1};
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff   = (frame_height_r == '0) ? 17'd1 : {1'b0, frame_height_r};
    col_inc = {{(EW-CW){1'b0}}, col_r} + {{(EW-1){1'b0}}, 1'b1};
    row_inc = {1'b0, row_r} + 17'd1;
    rend    = col_inc >= w_eff;
    fend    = rend && (row_inc >= h_eff);

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (rend) begin
        col_nxt = '0;
        row_nxt = fend ? 16'd0 : row_inc[15:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end

    s1_ctl_nxt.first_row = (row_r == '0);
    s1_ctl_nxt.first_col = (col_r == '0);
    s1_ctl_nxt.fwd       = s1_adv && (s1_x_r == col_r);
    s1_ctl_nxt.rend      = rend;
    s1_ctl_nxt.fend      = fend;
  end

  gpr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_x_r),
    .wdata (pix),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    up   = s1_ctl_r.first_row ? 8'd0 : (s1_ctl_r.fwd ? left_r : ram_rdata);
    lft  = s1_ctl_r.first_col ? 8'd0 : left_r;
    ul   = (s1_ctl_r.first_col || s1_ctl_r.first_row) ? 8'd0 : upleft_r;
    pred = lft + up - ul;
    if (mode_r == ModeDecode) begin
      pix           = s1_sample_r + pred;
      out_value_nxt = pix;
    end else begin
      pix           = s1_sample_r;
      out_value_nxt = s1_sample_r - pred;
    end
    left_nxt   = s1_adv ? pix : left_r;
    upleft_nxt = s1_adv ? up  : upleft_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      upleft_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      left_r   <= left_nxt;
      upleft_r <= upleft_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_ch.sample;
      s1_x_r      <= col_r;
      s1_ctl_r    <= s1_ctl_nxt;
    end
    if (s1_adv) begin
      out_value_r     <= out_value_nxt;
      out_row_end_r   <= s1_ctl_r.rend;
      out_frame_end_r <= s1_ctl_r.fend;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value     = out_value_r;
  assign out_ch.row_end   = out_row_end_r;
  assign out_ch.frame_end = out_frame_end_r;

  a_frame_end_in_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_frame_end_r || out_row_end_r))
    else $error("frame end without row end");

  a_row_end_restarts_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && rend) |=> (col_r == '0))
    else $error("column count did not restart at row end");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_sample_r) && $stable(s1_x_r)))
    else $error("stalled pixel lost in prediction stage");

  a_forward_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_ctl_nxt.fwd) |-> (s1_adv && s1_x_r == col_r))
    else $error("forward taken without matching write");

endmodule

`default_nettype wire
